// ===== src/btpm_pkg.sv =====
package btpm_pkg;

   localparam int MAX_TRIANGLES_DEF = 256;
   localparam int COORD_BITS_DEF = 12;
   localparam int HIT_BITS = 8;

   localparam logic [1:0] CMD_CLEAR = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   localparam logic [1:0] OFF_A = 2'd0;
   localparam logic [1:0] OFF_B = 2'd1;
   localparam logic [1:0] OFF_C = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RD_A,
      ST_RD_B,
      ST_RD_C,
      ST_LAT_C,
      ST_DIFF,
      ST_K,
      ST_U,
      ST_V,
      ST_TEST,
      ST_MUL,
      ST_DIV,
      ST_RND,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic       clear;
      logic       append;
      logic       start;
      logic       rd_en;
      logic [1:0] rd_off;
      logic       lat_a;
      logic       lat_b;
      logic       lat_c;
      logic       diff;
      logic       calc_k;
      logic       calc_u;
      logic       calc_v;
      logic       next_tri;
      logic       init_acc;
      logic       mul;
      logic       div_step;
      logic       rnd;
      logic [1:0] term;
      logic       load_out;
      logic       found;
   } ctrl_type;

   typedef struct packed {
      logic has_tri;
      logic tri_hit;
      logic div_last;
   } status_type;

endpackage

// ===== src/btpm_ctrl.sv =====
module btpm_ctrl
   import btpm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_command,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output ctrl_type   ctrl
);

   state_type state_ff, state_in;
   logic [1:0] term_ff, term_in;
   logic found_ff, found_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept = req_valid && req_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_command == CMD_QUERY) state_in = ST_SCAN;
         end
         ST_SCAN: state_in = status.has_tri ? ST_RD_A : ST_OUT;
         ST_RD_A: state_in = ST_RD_B;
         ST_RD_B: state_in = ST_RD_C;
         ST_RD_C: state_in = ST_LAT_C;
         ST_LAT_C: state_in = ST_DIFF;
         ST_DIFF: state_in = ST_K;
         ST_K: state_in = ST_U;
         ST_U: state_in = ST_V;
         ST_V: state_in = ST_TEST;
         ST_TEST: state_in = status.tri_hit ? ST_MUL : ST_SCAN;
         ST_MUL: state_in = ST_DIV;
         ST_DIV: state_in = status.div_last ? ST_RND : ST_DIV;
         ST_RND: state_in = (term_ff == 2'd3) ? ST_OUT : ST_MUL;
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctrl = '0;
      ctrl.term = term_ff;
      ctrl.found = found_ff;
      term_in = term_ff;
      found_in = found_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_command)
                  CMD_CLEAR: ctrl.clear = 1'b1;
                  CMD_APPEND: ctrl.append = 1'b1;
                  CMD_QUERY: begin
                     ctrl.start = 1'b1;
                     found_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD_A: begin
            ctrl.rd_en = 1'b1;
            ctrl.rd_off = OFF_A;
         end
         ST_RD_B: begin
            ctrl.rd_en = 1'b1;
            ctrl.rd_off = OFF_B;
            ctrl.lat_a = 1'b1;
         end
         ST_RD_C: begin
            ctrl.rd_en = 1'b1;
            ctrl.rd_off = OFF_C;
            ctrl.lat_b = 1'b1;
         end
         ST_LAT_C: ctrl.lat_c = 1'b1;
         ST_DIFF: ctrl.diff = 1'b1;
         ST_K: ctrl.calc_k = 1'b1;
         ST_U: ctrl.calc_u = 1'b1;
         ST_V: ctrl.calc_v = 1'b1;
         ST_TEST: begin
            if (status.tri_hit) begin
               ctrl.init_acc = 1'b1;
               found_in = 1'b1;
               term_in = 2'd0;
            end else begin
               ctrl.next_tri = 1'b1;
            end
         end
         ST_MUL: ctrl.mul = 1'b1;
         ST_DIV: ctrl.div_step = 1'b1;
         ST_RND: begin
            ctrl.rnd = 1'b1;
            term_in = term_ff + 2'd1;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               ctrl.load_out = 1'b1;
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         term_ff <= 2'd0;
         found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         term_ff <= term_in;
         found_ff <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== src/btpm_datapath.sv =====
module btpm_datapath
   import btpm_pkg::*;
#(
   parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
)(
   input  logic                         clock,
   input  logic                         reset,
   input  ctrl_type                     ctrl,
   output status_type                   status,
   input  logic signed [COORD_BITS-1:0] req_src_x,
   input  logic signed [COORD_BITS-1:0] req_src_y,
   input  logic signed [COORD_BITS-1:0] req_dst_x,
   input  logic signed [COORD_BITS-1:0] req_dst_y,
   input  logic signed [COORD_BITS-1:0] req_query_x,
   input  logic signed [COORD_BITS-1:0] req_query_y,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic                         rsp_found,
   output logic [HIT_BITS-1:0]          rsp_hit_triangle
);

   localparam int CB = COORD_BITS;
   localparam int DEPTH = 3 * MAX_TRIANGLES;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);
   localparam int D = CB + 1;          // difference width
   localparam int X = 2 * D + 1;       // cross product width
   localparam int PW = X + D;          // product width
   localparam int QW = $clog2(D);
   localparam int AccW = CB + 3;
   localparam logic signed [AccW-1:0] SAT_MAX = AccW'((1 << (CB - 1)) - 1);
   localparam logic signed [AccW-1:0] SAT_MIN = -SAT_MAX - AccW'(1);

   logic [2*CB-1:0] src_mem [DEPTH];
   logic [2*CB-1:0] dst_mem [DEPTH];
   logic [2*CB-1:0] src_rd_ff, dst_rd_ff;

   logic [CNTW-1:0] count_ff, base_ff;
   logic [HIT_BITS-1:0] z_ff;
   logic signed [CB-1:0] px_ff, py_ff;
   logic signed [CB-1:0] ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff;
   logic signed [CB-1:0] tax_ff, tay_ff, tbx_ff, tby_ff, tcx_ff, tcy_ff;
   logic signed [D-1:0] v0x_ff, v0y_ff, v1x_ff, v1y_ff, v2x_ff, v2y_ff;
   logic signed [D-1:0] dcx_ff, dcy_ff, dbx_ff, dby_ff;
   logic signed [X-1:0] kk_ff, bu_ff, bv_ff;
   logic kneg_ff, kzero_ff;
   logic [PW-1:0] r_ff;
   logic [D-1:0] q_ff;
   logic [QW-1:0] cnt_ff;
   logic dneg_ff;
   logic signed [AccW-1:0] accx_ff, accy_ff;
   logic signed [CB-1:0] outx_ff, outy_ff;
   logic found_ff;
   logic [HIT_BITS-1:0] hit_ff;

   logic [CNTW:0] base_end;
   logic [CNTW-1:0] rd_sum;
   logic [AW-1:0] rd_addr;
   logic signed [X-1:0] k_in, u_raw, v_raw;
   logic signed [X:0] sum_uv;
   logic signed [D-1:0] dsel;
   logic [D-1:0] mag;
   logic [X-1:0] num;
   logic [PW-1:0] trial;
   logic [X:0] twice_r;
   logic round_up;
   logic [D:0] q_rnd;
   logic signed [D+1:0] term_val;

   assign base_end = {1'b0, base_ff} + (CNTW+1)'(3);
   assign status.has_tri = base_end <= {1'b0, count_ff};
   assign sum_uv = bu_ff + bv_ff;
   assign status.tri_hit = !kzero_ff && !bu_ff[X-1] && (bu_ff < kk_ff) &&
                           !bv_ff[X-1] && (bv_ff < kk_ff) && (sum_uv <= kk_ff);
   assign status.div_last = (cnt_ff == '0);

   assign rd_sum = base_ff + CNTW'(ctrl.rd_off);
   assign rd_addr = rd_sum[AW-1:0];

   always_ff @(posedge clock) begin
      if (ctrl.append && count_ff < CNTW'(DEPTH)) begin
         src_mem[count_ff[AW-1:0]] <= {req_src_x, req_src_y};
         dst_mem[count_ff[AW-1:0]] <= {req_dst_x, req_dst_y};
      end
      if (ctrl.rd_en) begin
         src_rd_ff <= src_mem[rd_addr];
         dst_rd_ff <= dst_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (ctrl.clear) begin
         count_ff <= '0;
      end else if (ctrl.append && count_ff < CNTW'(DEPTH)) begin
         count_ff <= count_ff + CNTW'(1);
      end
   end

   assign k_in = v0x_ff * v1y_ff - v0y_ff * v1x_ff;
   assign u_raw = v2x_ff * v1y_ff - v2y_ff * v1x_ff;
   assign v_raw = v0x_ff * v2y_ff - v0y_ff * v2x_ff;

   // pick the numerator and target edge for this term
   always_comb begin
      case (ctrl.term)
         2'd0: dsel = dcx_ff;
         2'd1: dsel = dbx_ff;
         2'd2: dsel = dcy_ff;
         default: dsel = dby_ff;
      endcase
      mag = dsel[D-1] ? D'(-dsel) : D'(dsel);
      num = ctrl.term[0] ? X'(bv_ff) : X'(bu_ff);
   end

   assign trial = PW'(kk_ff) << cnt_ff;
   assign twice_r = {r_ff[X-1:0], 1'b0};
   assign round_up = (twice_r > {1'b0, kk_ff}) ||
                     ((twice_r == {1'b0, kk_ff}) && q_ff[0]);
   assign q_rnd = {1'b0, q_ff} + (D+1)'(round_up);
   assign term_val = dneg_ff ? -$signed({1'b0, q_rnd}) : $signed({1'b0, q_rnd});

   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         px_ff <= req_query_x;
         py_ff <= req_query_y;
         base_ff <= '0;
         z_ff <= '0;
      end
      if (ctrl.next_tri) begin
         base_ff <= base_ff + CNTW'(3);
         z_ff <= z_ff + HIT_BITS'(1);
      end
      if (ctrl.lat_a) begin
         {ax_ff, ay_ff} <= src_rd_ff;
         {tax_ff, tay_ff} <= dst_rd_ff;
      end
      if (ctrl.lat_b) begin
         {bx_ff, by_ff} <= src_rd_ff;
         {tbx_ff, tby_ff} <= dst_rd_ff;
      end
      if (ctrl.lat_c) begin
         {cx_ff, cy_ff} <= src_rd_ff;
         {tcx_ff, tcy_ff} <= dst_rd_ff;
      end
      if (ctrl.diff) begin
         v0x_ff <= D'(cx_ff) - D'(ax_ff);
         v0y_ff <= D'(cy_ff) - D'(ay_ff);
         v1x_ff <= D'(bx_ff) - D'(ax_ff);
         v1y_ff <= D'(by_ff) - D'(ay_ff);
         v2x_ff <= D'(px_ff) - D'(ax_ff);
         v2y_ff <= D'(py_ff) - D'(ay_ff);
         dcx_ff <= D'(tcx_ff) - D'(tax_ff);
         dcy_ff <= D'(tcy_ff) - D'(tay_ff);
         dbx_ff <= D'(tbx_ff) - D'(tax_ff);
         dby_ff <= D'(tby_ff) - D'(tay_ff);
      end
      if (ctrl.calc_k) begin
         kneg_ff <= k_in[X-1];
         kzero_ff <= (k_in == '0);
         kk_ff <= k_in[X-1] ? -k_in : k_in;
      end
      if (ctrl.calc_u) bu_ff <= kneg_ff ? -u_raw : u_raw;
      if (ctrl.calc_v) bv_ff <= kneg_ff ? -v_raw : v_raw;
      if (ctrl.init_acc) begin
         accx_ff <= AccW'(tax_ff);
         accy_ff <= AccW'(tay_ff);
      end
      if (ctrl.mul) begin
         r_ff <= PW'(num) * PW'(mag);
         q_ff <= '0;
         cnt_ff <= QW'(D - 1);
         dneg_ff <= dsel[D-1];
      end
      if (ctrl.div_step) begin
         if (r_ff >= trial) begin
            r_ff <= r_ff - trial;
            q_ff[cnt_ff] <= 1'b1;
         end
         cnt_ff <= cnt_ff - QW'(1);
      end
      if (ctrl.rnd) begin
         if (ctrl.term[1]) accy_ff <= accy_ff + term_val;
         else accx_ff <= accx_ff + term_val;
      end
      if (ctrl.load_out) begin
         found_ff <= ctrl.found;
         if (ctrl.found) begin
            outx_ff <= (accx_ff > SAT_MAX) ? CB'(SAT_MAX) :
                       (accx_ff < SAT_MIN) ? CB'(SAT_MIN) : CB'(accx_ff);
            outy_ff <= (accy_ff > SAT_MAX) ? CB'(SAT_MAX) :
                       (accy_ff < SAT_MIN) ? CB'(SAT_MIN) : CB'(accy_ff);
            hit_ff <= z_ff;
         end else begin
            outx_ff <= px_ff;
            outy_ff <= py_ff;
            hit_ff <= '0;
         end
      end
   end

   assign rsp_out_x = outx_ff;
   assign rsp_out_y = outy_ff;
   assign rsp_found = found_ff;
   assign rsp_hit_triangle = hit_ff;

endmodule

// ===== src/barycentric_triangle_point_mapper.sv =====
// Channel   Direction  Handshake             Beat
// req_*     in         req_valid/req_ready   command, source/target corner, query point
// rsp_*     out        rsp_valid/rsp_ready   mapped point, found flag, triangle index
//
// Clear and append are done in the idle state that accepts them. A query checks
// each triangle in turn: read three corners, form differences and cross products,
// then test. A hit skips the closing list check and computes the four rounded
// fractions, which share one bit-per-cycle divider.
// The scan is bounded by the single read port of the corner memories.
// Reset empties the triangle list; the corner memories are not cleared.
// A finished result waits in the output register; the next command is taken
// while it waits, and a later query holds its result until rsp_ready frees it.
module barycentric_triangle_point_mapper
   import btpm_pkg::*;
#(
   parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
)(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [1:0]                   req_command,
   input  logic signed [COORD_BITS-1:0] req_src_x,
   input  logic signed [COORD_BITS-1:0] req_src_y,
   input  logic signed [COORD_BITS-1:0] req_dst_x,
   input  logic signed [COORD_BITS-1:0] req_dst_y,
   input  logic signed [COORD_BITS-1:0] req_query_x,
   input  logic signed [COORD_BITS-1:0] req_query_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [COORD_BITS-1:0] rsp_out_x,
   output logic signed [COORD_BITS-1:0] rsp_out_y,
   output logic                         rsp_found,
   output logic [HIT_BITS-1:0]          rsp_hit_triangle
);

   ctrl_type ctrl;
   status_type status;

   // sequencer: walks the triangle list and the four rounding terms
   btpm_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_command),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .status      (status),
      .ctrl        (ctrl)
   );

   // corner memories, cross products, divider and output register
   btpm_datapath #(
      .MAX_TRIANGLES (MAX_TRIANGLES),
      .COORD_BITS    (COORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .status           (status),
      .req_src_x        (req_src_x),
      .req_src_y        (req_src_y),
      .req_dst_x        (req_dst_x),
      .req_dst_y        (req_dst_y),
      .req_query_x      (req_query_x),
      .req_query_y      (req_query_y),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_found        (rsp_found),
      .rsp_hit_triangle (rsp_hit_triangle)
   );

endmodule

// ===== tb/barycentric_triangle_point_mapper_tb.sv =====
`timescale 1ns / 100ps

module barycentric_triangle_point_mapper_tb;
   import btpm_pkg::*;

   localparam int CB = COORD_BITS_DEF;
   localparam int CORNERS = 3 * MAX_TRIANGLES_DEF;
   // worst query: a scan of every triangle plus the rounding divider for all four terms
   localparam int QUERY_CYCLES = 3 + 10 * MAX_TRIANGLES_DEF + 4 * (CB + 3);
   localparam int CYCLE_LIMIT = 1500000;
   localparam int LONG_HOLD = 400;
   localparam int LONG_TRIS = 40;

   typedef logic signed [CB-1:0] coord_type;

   typedef struct {
      coord_type    x;
      coord_type    y;
      logic         found;
      logic [7:0]   hit;
   } mapped_type;

   typedef struct {
      logic [1:0] cmd;
      coord_type  sx, sy, dx, dy, qx, qy;
      bit         typed;
      mapped_type want;
   } beat_type;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   logic [1:0]    req_command;
   coord_type     req_src_x, req_src_y, req_dst_x, req_dst_y, req_query_x, req_query_y;
   logic          rsp_valid;
   logic          rsp_ready;
   coord_type     rsp_out_x, rsp_out_y;
   logic          rsp_found;
   logic [7:0]    rsp_hit_triangle;

   // predictor state: its own copy of the corner lists
   longint        src_cx[CORNERS], src_cy[CORNERS], dst_cx[CORNERS], dst_cy[CORNERS];
   int            n_corners;

   mapped_type    mapped_q[$];
   beat_type      script[$];
   int            errors;
   int            n_checked;
   int            n_hits;
   int            n_queries;
   longint        cycles;
   bit            idling_on;
   bit            hold_rsp;

   barycentric_triangle_point_mapper i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_src_x        (req_src_x),
      .req_src_y        (req_src_y),
      .req_dst_x        (req_dst_x),
      .req_dst_y        (req_dst_y),
      .req_query_x      (req_query_x),
      .req_query_y      (req_query_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_out_x        (rsp_out_x),
      .rsp_out_y        (rsp_out_y),
      .rsp_found        (rsp_found),
      .rsp_hit_triangle (rsp_hit_triangle)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // cycle counter doubles as the watchdog
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles, mapped_q.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   function automatic longint sat_coord(longint v);
      longint hi, lo;
      hi = (longint'(1) <<< (CB - 1)) - 1;
      lo = -(longint'(1) <<< (CB - 1));
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
   endfunction

   // round(num * delta / k) to nearest, ties to even; 0 <= num < k
   function automatic longint share_round(longint num, longint delta, longint k);
      longint mag, p, q, r;
      mag = delta < 0 ? -delta : delta;
      p = num * mag;
      q = p / k;
      r = p % k;
      if (2 * r > k || (2 * r == k && q[0])) q++;
      return delta < 0 ? -q : q;
   endfunction

   // advance the predictor by one accepted beat; a query yields one result
   task automatic map_point(input beat_type b, output bit has, output mapped_type m);
      longint px, py, v0x, v0y, v1x, v1y, v2x, v2y, k, bu, bv;
      int a;
      has = 1'b0;
      m = '{x: b.qx, y: b.qy, found: 1'b0, hit: 8'd0};
      case (b.cmd)
         CMD_CLEAR: n_corners = 0;
         CMD_APPEND: begin
            if (n_corners < CORNERS) begin
               src_cx[n_corners] = b.sx;
               src_cy[n_corners] = b.sy;
               dst_cx[n_corners] = b.dx;
               dst_cy[n_corners] = b.dy;
               n_corners++;
            end
         end
         CMD_QUERY: begin
            has = 1'b1;
            px = b.qx;
            py = b.qy;
            for (int z = 0; z < n_corners / 3; z++) begin
               a = 3 * z;
               v0x = src_cx[a+2] - src_cx[a];
               v0y = src_cy[a+2] - src_cy[a];
               v1x = src_cx[a+1] - src_cx[a];
               v1y = src_cy[a+1] - src_cy[a];
               v2x = px - src_cx[a];
               v2y = py - src_cy[a];
               k = v0x * v1y - v0y * v1x;
               if (k == 0) continue;
               bu = v2x * v1y - v2y * v1x;
               bv = v0x * v2y - v0y * v2x;
               if (k < 0) begin
                  k = -k;
                  bu = -bu;
                  bv = -bv;
               end
               if (bu >= 0 && bu < k && bv >= 0 && bv < k && bu + bv <= k) begin
                  m.x = coord_type'(sat_coord(dst_cx[a]
                        + share_round(bu, dst_cx[a+2] - dst_cx[a], k)
                        + share_round(bv, dst_cx[a+1] - dst_cx[a], k)));
                  m.y = coord_type'(sat_coord(dst_cy[a]
                        + share_round(bu, dst_cy[a+2] - dst_cy[a], k)
                        + share_round(bv, dst_cy[a+1] - dst_cy[a], k)));
                  m.found = 1'b1;
                  m.hit = 8'(z);
                  break;
               end
            end
         end
         default: ;
      endcase
   endtask

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
      errors++;
   endtask

   // one beat on the request side; entered and left at a falling edge
   task automatic send_beat(input beat_type b);
      bit has;
      mapped_type m;
      if (idling_on && $urandom_range(0, 5) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
      req_command = b.cmd;
      req_src_x = b.sx;
      req_src_y = b.sy;
      req_dst_x = b.dx;
      req_dst_y = b.dy;
      req_query_x = b.qx;
      req_query_y = b.qy;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      map_point(b, has, m);
      if (has) begin
         if (b.typed) m = b.want;
         mapped_q = {mapped_q, m};
         n_queries++;
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (mapped_q.size() != 0) @(negedge clock);
   endtask

   function automatic coord_type any_coord();
      return coord_type'($urandom_range(0, (1 << CB) - 1));
   endfunction

   function automatic coord_type clampc(longint v);
      return coord_type'(sat_coord(v));
   endfunction

   function automatic beat_type mk(logic [1:0] cmd, longint sx, longint sy, longint dx,
                                   longint dy, longint qx, longint qy);
      beat_type b;
      b.cmd = cmd;
      b.sx = clampc(sx);
      b.sy = clampc(sy);
      b.dx = clampc(dx);
      b.dy = clampc(dy);
      b.qx = clampc(qx);
      b.qy = clampc(qy);
      b.typed = 1'b0;
      b.want = '{x: '0, y: '0, found: 1'b0, hit: 8'd0};
      return b;
   endfunction

   function automatic beat_type mk_query(longint qx, longint qy, bit typed,
                                         longint wx, longint wy, bit wf);
      beat_type b;
      b = mk(CMD_QUERY, 0, 0, 0, 0, qx, qy);
      b.sx = any_coord();
      b.dy = any_coord();
      b.typed = typed;
      b.want = '{x: clampc(wx), y: clampc(wy), found: wf, hit: 8'd0};
      return b;
   endfunction

   // random triangle: full-range corners or a small one around a random spot
   task automatic push_triangle(inout beat_type q[$]);
      longint ax, ay;
      bit tiny;
      tiny = $urandom_range(0, 2) != 0;
      ax = any_coord();
      ay = any_coord();
      for (int i = 0; i < 3; i++) begin
         if (tiny)
            q = {q, mk(CMD_APPEND, ax + $signed($urandom_range(0, 80)) - 40,
                       ay + $signed($urandom_range(0, 80)) - 40,
                       any_coord(), any_coord(), any_coord(), any_coord())};
         else
            q = {q, mk(CMD_APPEND, any_coord(), any_coord(), any_coord(),
                       any_coord(), any_coord(), any_coord())};
      end
   endtask

   // a point aimed inside stored triangle z, with a weighted corner blend
   function automatic beat_type aim_query(int z);
      longint w1, w2, wt, qx, qy;
      int a;
      a = 3 * z;
      wt = 64;
      w1 = $urandom_range(0, 64);
      w2 = $urandom_range(0, 64 - w1);
      qx = src_cx[a] + (w1 * (src_cx[a+1] - src_cx[a]) + w2 * (src_cx[a+2] - src_cx[a])) / wt;
      qy = src_cy[a] + (w1 * (src_cy[a+1] - src_cy[a]) + w2 * (src_cy[a+2] - src_cy[a])) / wt;
      return mk_query(qx, qy, 1'b0, 0, 0, 1'b0);
   endfunction

   // result side: random stalls, plus one long hold on request
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            rsp_ready = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clock);
         end else begin
            rsp_ready = 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      mapped_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         n_checked++;
         if (mapped_q.size() == 0) begin
            report_mismatch("result count", n_checked, n_queries);
         end else begin
            w = mapped_q.pop_front();
            if (rsp_out_x !== w.x) report_mismatch("out_x", rsp_out_x, w.x);
            if (rsp_out_y !== w.y) report_mismatch("out_y", rsp_out_y, w.y);
            if (rsp_found !== w.found) report_mismatch("found", rsp_found, w.found);
            if (rsp_hit_triangle !== w.hit)
               report_mismatch("hit_triangle", rsp_hit_triangle, w.hit);
            if (rsp_found === 1'b1) n_hits++;
         end
      end
   end

   initial begin
      beat_type b;
      beat_type seg[$];
      int n_random;
      int ntri;
      errors = 0;
      n_checked = 0;
      n_hits = 0;
      n_queries = 0;
      n_corners = 0;
      idling_on = 1'b1;
      hold_rsp = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_CLEAR;
      req_src_x = '0;
      req_src_y = '0;
      req_dst_x = '0;
      req_dst_y = '0;
      req_query_x = '0;
      req_query_y = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty list, ignored command, partial triangle, identity map,
      // corner and edge of the half-open test, degenerate, extremes, clear
      script = {script, mk_query(5, -7, 1'b1, 5, -7, 1'b0)};
      script = {script, mk(CMD_SPARE, any_coord(), any_coord(), any_coord(), any_coord(),
                           any_coord(), any_coord())};
      script = {script, mk(CMD_APPEND, 0, 0, 0, 0, 0, 0)};
      script = {script, mk_query(1, 1, 1'b1, 1, 1, 1'b0)};
      script = {script, mk(CMD_APPEND, 0, 100, 0, 100, 0, 0)};
      script = {script, mk(CMD_APPEND, 100, 0, 100, 0, 0, 0)};
      script = {script, mk_query(10, 20, 1'b1, 10, 20, 1'b1)};
      script = {script, mk_query(0, 0, 1'b1, 0, 0, 1'b1)};
      script = {script, mk_query(100, 0, 1'b1, 100, 0, 1'b0)};
      script = {script, mk(CMD_APPEND, -2048, -2048, 2047, -2048, 0, 0)};
      script = {script, mk(CMD_APPEND, 2047, 2047, -2048, 2047, 0, 0)};
      script = {script, mk(CMD_APPEND, 0, 0, 2047, 2047, 0, 0)};
      script = {script, mk_query(-2048, 2047, 1'b1, -2048, 2047, 1'b0)};
      script = {script, mk(CMD_APPEND, -2048, -2048, 2047, 2047, -1, -1)};
      script = {script, mk(CMD_APPEND, -2048, 2047, -2048, -2048, 0, 0)};
      script = {script, mk(CMD_APPEND, 2047, -2048, 2047, -2048, 0, 0)};
      script = {script, mk_query(-2000, -2000, 1'b0, 0, 0, 1'b0)};
      script = {script, mk_query(-2048, -2048, 1'b0, 0, 0, 1'b0)};
      script = {script, mk_query(1000, -1000, 1'b0, 0, 0, 1'b0)};
      script = {script, mk_query(-1, -1, 1'b0, 0, 0, 1'b0)};
      script = {script, mk(CMD_CLEAR, any_coord(), any_coord(), any_coord(), any_coord(),
                           any_coord(), any_coord())};
      script = {script, mk_query(2047, -2048, 1'b1, 2047, -2048, 1'b0)};
      foreach (script[i]) send_beat(script[i]);
      wait_drained();

      // build a long list with two trailing corners, then aim deep into it
      send_beat(mk(CMD_CLEAR, 0, 0, 0, 0, 0, 0));
      for (int t = 0; t < LONG_TRIS; t++) begin
         seg.delete();
         push_triangle(seg);
         foreach (seg[i]) send_beat(seg[i]);
      end
      send_beat(mk(CMD_APPEND, 0, 0, 0, 0, 0, 0));
      send_beat(mk(CMD_APPEND, -2048, 2047, 2047, -2048, 0, 0));
      send_beat(aim_query(LONG_TRIS - 1));
      send_beat(aim_query(LONG_TRIS / 2));
      send_beat(mk_query(any_coord(), any_coord(), 1'b0, 0, 0, 1'b0));
      // pause the sender until every pending result is back
      wait_drained();

      // random: build short lists, mostly aimed queries, some noise
      n_random = 0;
      while (n_random < 420) begin
         seg.delete();
         if ($urandom_range(0, 4) != 0)
            seg = {seg, mk(CMD_CLEAR, any_coord(), any_coord(), any_coord(),
                           any_coord(), any_coord(), any_coord())};
         repeat ($urandom_range(1, 5)) push_triangle(seg);
         if ($urandom_range(0, 5) == 0)
            seg = {seg, mk(CMD_APPEND, any_coord(), any_coord(), any_coord(),
                           any_coord(), any_coord(), any_coord())};
         foreach (seg[i]) send_beat(seg[i]);
         n_random += seg.size();

         // hold the result side for a long stretch, while beats keep coming
         if (n_random > 100 && n_random < 140 && !hold_rsp) hold_rsp = 1'b1;
         if (n_random > 340) idling_on = 1'b0;

         ntri = n_corners / 3;
         repeat ($urandom_range(3, 8)) begin
            case ($urandom_range(0, 9))
               0: b = mk(CMD_SPARE, any_coord(), any_coord(), any_coord(), any_coord(),
                         any_coord(), any_coord());
               1, 2: b = mk_query(any_coord(), any_coord(), 1'b0, 0, 0, 1'b0);
               default: b = ntri > 0 ? aim_query($urandom_range(0, ntri - 1))
                                     : mk_query(any_coord(), any_coord(), 1'b0, 0, 0, 1'b0);
            endcase
            send_beat(b);
            n_random++;
         end
      end

      wait_drained();
      repeat (QUERY_CYCLES) @(negedge clock);
      $display("covered %0d queries (%0d hits) over clear, append, long list and ignored beats",
               n_queries, n_hits);
      $display("checked %0d result beats, %0d mismatches", n_checked, errors);
      if (errors == 0 && mapped_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
